@@ hdl/lsr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsr_pkg: shared types and constants for the Laplacian sharpening block
// Widths, frame limits, register map and the per-channel sharpen function.
// ----------------------------------------------------------------------------
package lsr_pkg;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = 10;
	localparam int ROW_W      = 12;
	localparam int FW_W       = 11;
	localparam int FH_W       = 13;
	localparam int PIX_W      = 24;
	localparam int ADDR_W     = 3;

	localparam logic [ADDR_W-1:0] REG_WIDTH  = 3'd0;
	localparam logic [ADDR_W-1:0] REG_HEIGHT = 3'd4;

	// one result word as it leaves the block
	typedef struct packed {
		logic             eof;
		logic             last;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
	} res_t;

	// per-channel four-neighbour sharpening
	function automatic logic [7:0] sharpen8(input logic [7:0] c, input logic [7:0] l,
			input logic [7:0] r, input logic [7:0] u, input logic [7:0] d);
		logic [10:0] lap;
		logic [9:0]  s;
		logic [10:0] c4;
		logic [8:0]  v;
		begin
			s   = 10'(l) + 10'(r) + 10'(u) + 10'(d);
			c4  = {1'b0, c, 2'b00};
			if (11'(s) <= c4) lap = 11'd0;
			else lap = 11'(s) - c4;
			if (lap > 11'd255) lap = 11'd255;
			v = 9'(c) + lap[8:0];
			sharpen8 = v[8] ? 8'hff : v[7:0];
		end
	endfunction

	function automatic logic [PIX_W-1:0] sharpen24(input logic [PIX_W-1:0] c,
			input logic [PIX_W-1:0] l, input logic [PIX_W-1:0] r,
			input logic [PIX_W-1:0] u, input logic [PIX_W-1:0] d);
		begin
			sharpen24 = {sharpen8(c[23:16], l[23:16], r[23:16], u[23:16], d[23:16]),
				sharpen8(c[15:8], l[15:8], r[15:8], u[15:8], d[15:8]),
				sharpen8(c[7:0], l[7:0], r[7:0], u[7:0], d[7:0])};
		end
	endfunction
endpackage
`default_nettype wire

@@ hdl/laplacian_sharpen_rgb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// laplacian_sharpen_rgb: streaming four-neighbour Laplacian sharpening, RGB
// Two line stores, reflect-101 borders, up to four results per pixel.
// ----------------------------------------------------------------------------
// One pixel word is taken per clock when the output side keeps up. A word
// passes a store-read stage and a stencil stage, then a four-entry output
// buffer drains one result word a cycle while m_axis_tready is high. Pixels
// of rows other than the last give at most two results; on the last row a
// pixel gives up to four, which leave through the single output port in
// turn. Line stores are 1024 x 24-bit RAMs with a registered read; a write
// and read of the same column in the same cycle is forwarded.
// Results carry row and column; tlast marks the last result caused by an
// input word. Change frame_width/frame_height only while idle.
// ----------------------------------------------------------------------------
module laplacian_sharpen_rgb (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [23:0] s_axis_tdata,   // blue, green, red
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [47:0] m_axis_tdata,   // blue, green, red, row, col, end_of_frame, pad
	output logic        m_axis_tlast    // last_of_run
);
	import lsr_pkg::*;

	logic [FW_W-1:0] fw_q;
	logic [FH_W-1:0] fh_q;
	logic            adv, vld_s2;
	logic [2:0]      cnt_s2, left_q, idx_q;
	res_t            res_s2 [4];
	res_t            buf_q [4];
	res_t            cur;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FW_W'(1024);
			fh_q <= FH_W'(1024);
		end else if (psel && penable && pwrite) begin
			if (paddr == REG_WIDTH) fw_q <= pwdata[FW_W-1:0];
			if (paddr == REG_HEIGHT) fh_q <= pwdata[FH_W-1:0];
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr == REG_WIDTH) prdata = 32'(fw_q);
		else if (paddr == REG_HEIGHT) prdata = 32'(fh_q);
	end

	// pipeline moves when the output buffer is empty or drains its final word
	assign adv = (left_q == '0) || (left_q == 3'd1 && m_axis_tready);
	assign s_axis_tready = adv;

	lsr_core u_core (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_ok(s_axis_tvalid),
		.pix(s_axis_tdata), .frame_width(fw_q), .frame_height(fh_q),
		.vld_s2(vld_s2), .cnt_s2(cnt_s2), .res_s2(res_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			idx_q  <= '0;
		end else if (adv) begin
			left_q <= vld_s2 ? cnt_s2 : '0;
			idx_q  <= '0;
		end else if (m_axis_tready) begin
			left_q <= left_q - 1'b1;
			idx_q  <= idx_q + 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv && vld_s2) buf_q <= res_s2;
	end

	assign cur = buf_q[idx_q[1:0]];
	assign m_axis_tvalid = (left_q != '0);
	assign m_axis_tlast  = (left_q == 3'd1);
	assign m_axis_tdata  = {1'b0, cur.eof, cur.col, cur.row, cur.red, cur.green, cur.blue};
endmodule
`default_nettype wire

@@ hdl/lsr_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsr_ram: generic single-port-write, single-port-read RAM
// Registered read.
// ----------------------------------------------------------------------------
module lsr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ hdl/lsr_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsr_core: line stores, window and stencil
// Stage 1 reads both line stores; stage 2 forms up to four results.
// ----------------------------------------------------------------------------
module lsr_core (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        adv,
	input  wire                        in_ok,
	input  wire [lsr_pkg::PIX_W-1:0]   pix,
	input  wire [lsr_pkg::FW_W-1:0]    frame_width,
	input  wire [lsr_pkg::FH_W-1:0]    frame_height,
	output logic                       vld_s2,
	output logic [2:0]                 cnt_s2,
	output lsr_pkg::res_t              res_s2 [4]
);
	import lsr_pkg::*;

	logic [COL_W:0]   w;
	logic [ROW_W:0]   h;
	logic [COL_W-1:0] col_q, c;
	logic [ROW_W-1:0] row_q, r;
	logic             vld_s1;
	logic [COL_W-1:0] c_s1;
	logic [ROW_W-1:0] r_s1;
	logic [PIX_W-1:0] x_s1;
	logic [PIX_W-1:0] p_rd, o_rd;
	logic [PIX_W-1:0] win_q [6];
	logic [COL_W:0]   wm1_s1;
	logic [ROW_W:0]   hm1_s1;
	logic             take;
	// forwarding of store writes issued in stage 1 to a same-address read
	logic             fwd_s1;
	logic [PIX_W-1:0] fp_s1, fo_s1, p, o;

	always_comb begin
		if (frame_width < FW_W'(2)) w = (COL_W+1)'(2);
		else if (frame_width > FW_W'(MAX_WIDTH)) w = (COL_W+1)'(MAX_WIDTH);
		else w = frame_width[COL_W:0];
		if (frame_height < FH_W'(2)) h = (ROW_W+1)'(2);
		else if (frame_height > FH_W'(MAX_HEIGHT)) h = (ROW_W+1)'(MAX_HEIGHT);
		else h = frame_height[ROW_W:0];
		c = ({1'b0, col_q} < w) ? col_q : COL_W'(w - 1'b1);
		r = ({1'b0, row_q} < h) ? row_q : ROW_W'(h - 1'b1);
	end

	assign take = in_ok && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_ok;
			if (in_ok) begin
				if ({1'b0, c} >= w - 1'b1) begin
					col_q <= '0;
					row_q <= ({1'b0, r} >= h - 1'b1) ? '0 : r + 1'b1;
				end else begin
					col_q <= c + 1'b1;
					row_q <= r;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1   <= c;
			r_s1   <= r;
			x_s1   <= pix;
			wm1_s1 <= w - 1'b1;
			hm1_s1 <= h - 1'b1;
			fwd_s1 <= vld_s1 && (c_s1 == c);
			fp_s1  <= x_s1;
			fo_s1  <= p;
		end
	end

	assign p = fwd_s1 ? fp_s1 : p_rd;
	assign o = fwd_s1 ? fo_s1 : o_rd;

	lsr_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_prev (
		.clk(clk), .we(vld_s1 && adv), .waddr(c_s1), .wdata(x_s1),
		.re(take), .raddr(c), .rdata(p_rd)
	);
	lsr_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_old (
		.clk(clk), .we(vld_s1 && adv && r_s1 != '0), .waddr(c_s1), .wdata(p),
		.re(take), .raddr(c), .rdata(o_rd)
	);

	// stage 2: stencil and result list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			cnt_s2 <= '0;
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else if (adv) begin
			vld_s2 <= 1'b0;
			cnt_s2 <= '0;
			if (vld_s1) begin
				automatic logic lastr = ({1'b0, r_s1} == hm1_s1);
				automatic logic lastc = ({1'b0, c_s1} == wm1_s1);
				automatic logic [2:0] n = '0;
				automatic res_t e;
				automatic logic [PIX_W-1:0] pr = (r_s1 != '0) ? p : '0;
				automatic logic [PIX_W-1:0] ol = (r_s1 >= ROW_W'(2)) ? o : '0;
				if (r_s1 != '0 && c_s1 != '0) begin
					e.blue = '0;
					{e.red, e.green, e.blue} = sharpen24(win_q[2],
						(c_s1 == COL_W'(1)) ? pr : win_q[3], pr,
						(r_s1 == ROW_W'(1)) ? win_q[0] : win_q[4], win_q[0]);
					e.row = r_s1 - 1'b1; e.col = c_s1 - 1'b1; e.last = 1'b0;
					e.eof = 1'b0;
					res_s2[n[1:0]] <= e; n = n + 1'b1;
					if (lastr) begin
						{e.red, e.green, e.blue} = sharpen24(win_q[0],
							(c_s1 == COL_W'(1)) ? x_s1 : win_q[1], x_s1,
							win_q[2], win_q[2]);
						e.row = r_s1;
						e.eof = ({1'b0, c_s1} - 1'b1 == wm1_s1);
						res_s2[n[1:0]] <= e; n = n + 1'b1;
					end
				end
				if (r_s1 != '0 && lastc) begin
					{e.red, e.green, e.blue} = sharpen24(pr, win_q[2], win_q[2],
						(r_s1 == ROW_W'(1)) ? x_s1 : ol, x_s1);
					e.row = r_s1 - 1'b1; e.col = c_s1; e.last = 1'b0;
					e.eof = ({1'b0, r_s1} - 1'b1 == hm1_s1);
					res_s2[n[1:0]] <= e; n = n + 1'b1;
					if (lastr) begin
						{e.red, e.green, e.blue} = sharpen24(x_s1, win_q[0], win_q[0],
							pr, pr);
						e.row = r_s1; e.eof = 1'b1;
						res_s2[n[1:0]] <= e; n = n + 1'b1;
					end
				end
				vld_s2 <= (n != '0);
				cnt_s2 <= n;
				win_q[1] <= win_q[0]; win_q[0] <= x_s1;
				win_q[3] <= win_q[2]; win_q[2] <= pr;
				win_q[5] <= win_q[4]; win_q[4] <= ol;
			end
		end
	end
endmodule
`default_nettype wire

@@ hdl/lsr_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsr_checker: port-level checks for laplacian_sharpen_rgb
// Output stability and result framing.
// ----------------------------------------------------------------------------
module lsr_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [47:0] m_axis_tdata,
	input wire        m_axis_tlast
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input taken mid-run");
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
		else $error("run ended without tlast");
endmodule

bind laplacian_sharpen_rgb lsr_checker u_chk (.*);
`default_nettype wire
